// ===== hdl/scad_pkg.sv =====
// shared types, character codes and register indexes for the serial command decoder
package scad_pkg;

    // byte window depth and field widths
    localparam int unsigned WinLen    = 7;
    localparam int unsigned FillW     = 3;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned InDataW   = 8;
    localparam int unsigned OutDataW  = 72;

    // frame characters
    localparam logic [7:0] ChDollar   = 8'h24;  // '$'
    localparam logic [7:0] ChA        = 8'h41;  // 'A'
    localparam logic [7:0] ChSeven    = 8'h37;  // '7'
    localparam logic [7:0] ChLf       = 8'h0A;  // line feed

    // command codes
    localparam logic [7:0] CmdMotor   = 8'h4D;  // 'M'
    localparam logic [7:0] CmdSteer   = 8'h44;  // 'D'
    localparam logic [7:0] CmdGps     = 8'h47;  // 'G'
    localparam logic [7:0] CmdCamera  = 8'h43;  // 'C'

    // sub codes
    localparam logic [7:0] SubBack    = 8'h21;  // '!'
    localparam logic [7:0] SubFwd     = 8'h25;  // '%'
    localparam logic [7:0] SubStop    = 8'h29;  // ')'
    localparam logic [7:0] SubOff     = 8'h30;  // '0'
    localparam logic [7:0] SubOn      = 8'h31;  // '1'
    localparam logic [7:0] SubCamA    = 8'h31;  // '1'
    localparam logic [7:0] SubCamB    = 8'h32;  // '2'
    localparam logic [7:0] SubCamEn   = 8'h33;  // '3'
    localparam logic [7:0] SubCamPwr  = 8'h35;  // '5'

    // enable flag bit positions
    localparam logic [1:0] FlagSteer  = 2'd0;
    localparam logic [1:0] FlagGps    = 2'd1;
    localparam logic [1:0] FlagCamEn  = 2'd2;
    localparam logic [1:0] FlagCamPwr = 2'd3;

    // reset values
    localparam logic [13:0] RstServoCenter = 14'd280;
    localparam logic [3:0]  RstServoStep   = 4'd5;
    localparam logic [7:0]  RstMotorGain   = 8'd146;
    localparam logic [15:0] RstStopDuty    = 16'd63;
    localparam logic [15:0] RstServo       = 16'd280;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SERVO_CENTER = 2'd0,
        CFG_SERVO_STEP   = 2'd1,
        CFG_MOTOR_GAIN   = 2'd2,
        CFG_STOP_DUTY    = 2'd3
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic [13:0] servo_center;
        logic [3:0]  servo_step;
        logic [7:0]  motor_gain;
        logic [15:0] stop_duty;
    } t_cfg;

    // decoded frame from the byte window
    typedef struct packed {
        logic       match;
        logic [7:0] cmd;
        logic [7:0] sub;
        logic [7:0] val;
    } t_frame;

    // actuator register set
    typedef struct packed {
        logic [15:0] duty;
        logic [1:0]  dir;      // bit0 forward, bit1 backward
        logic [15:0] steer;
        logic [15:0] cam_a;
        logic [15:0] cam_b;
        logic [3:0]  flags;    // steer, gps, cam servos, camera power
    } t_act;

endpackage

// ===== hdl/scad_window.sv =====
// seven byte receive window with frame match detection
module scad_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_byte,
    output scad_pkg::t_frame      o_frame,
    output logic [scad_pkg::FillW-1:0] o_fill
);
    import scad_pkg::*;

    logic [7:0]       r_win [WinLen];
    logic [FillW-1:0] r_fill;
    logic             w_match;

    // frame match on line feed with a full window and the header in place
    assign w_match = (i_byte == ChLf) && (r_fill == FillW'(WinLen)) &&
                     (r_win[0] == ChDollar) && (r_win[1] == ChA) &&
                     (r_win[2] == ChSeven);

    assign o_frame.match = w_match;
    assign o_frame.cmd   = r_win[3];
    assign o_frame.sub   = r_win[4];
    assign o_frame.val   = r_win[5];
    assign o_fill        = r_fill;

    // shift in the new byte, or clear everything on a match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < WinLen; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_en) begin
            if (w_match) begin
                r_fill <= '0;
                for (int i = 0; i < WinLen; i++) begin
                    r_win[i] <= '0;
                end
            end else begin
                for (int i = 0; i < WinLen - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WinLen-1] <= i_byte;
                if (r_fill != FillW'(WinLen)) begin
                    r_fill <= r_fill + FillW'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/scad_actuator.sv =====
// actuator registers updated by decoded command frames
module scad_actuator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  scad_pkg::t_frame  i_frame,
    input  scad_pkg::t_cfg    i_cfg,
    output scad_pkg::t_act    o_act
);
    import scad_pkg::*;

    t_act        r_act;
    t_act        n_act;
    logic [15:0] w_motor;
    logic [11:0] w_servo_prod;
    logic [15:0] w_servo;

    // set or clear one flag on an on or off code, other codes leave it
    function automatic logic [3:0] set_flag(input logic [3:0] flags,
                                            input logic [1:0] pos,
                                            input logic [7:0] code);
        logic [3:0] res;
        res = flags;
        if (code == SubOn) begin
            res[pos] = 1'b1;
        end else if (code == SubOff) begin
            res[pos] = 1'b0;
        end
        return res;
    endfunction

    // motor duty and servo compare arithmetic
    assign w_motor      = {8'd0, i_cfg.motor_gain} * {8'd0, i_frame.val};
    assign w_servo_prod = {8'd0, i_cfg.servo_step} * {4'd0, i_frame.val};
    assign w_servo      = {2'd0, i_cfg.servo_center} + {4'd0, w_servo_prod};

    // command decode
    always_comb begin
        n_act = r_act;
        case (i_frame.cmd)
            CmdMotor: begin
                case (i_frame.sub)
                    SubBack: begin
                        n_act.dir  = 2'b10;
                        n_act.duty = w_motor;
                    end
                    SubFwd: begin
                        n_act.dir  = 2'b01;
                        n_act.duty = w_motor;
                    end
                    SubStop: begin
                        n_act.dir  = 2'b11;
                        n_act.duty = i_cfg.stop_duty;
                    end
                    default: ;
                endcase
            end
            CmdSteer: begin
                n_act.flags = set_flag(r_act.flags, FlagSteer, i_frame.sub);
                n_act.steer = w_servo;
            end
            CmdGps: begin
                n_act.flags = set_flag(r_act.flags, FlagGps, i_frame.sub);
            end
            CmdCamera: begin
                case (i_frame.sub)
                    SubCamA:   n_act.cam_a = w_servo;
                    SubCamB:   n_act.cam_b = w_servo;
                    SubCamEn:  n_act.flags = set_flag(r_act.flags, FlagCamEn, i_frame.val);
                    SubCamPwr: n_act.flags = set_flag(r_act.flags, FlagCamPwr, i_frame.val);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // register update on a matched frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act.duty  <= '0;
            r_act.dir   <= '0;
            r_act.steer <= RstServo;
            r_act.cam_a <= RstServo;
            r_act.cam_b <= RstServo;
            r_act.flags <= '1;
        end else if (i_en && i_frame.match) begin
            r_act <= n_act;
        end
    end

    assign o_act = r_act;

endmodule

// ===== hdl/serial_command_actuator_decoder_core.sv =====
// top level: input register, frame decode and actuator result registers
// an accepted byte updates the window and actuator registers as it passes on
// throughput: one byte per cycle when the result stage is free; the input register
//   feeds the window and actuator registers, which are the result on the output
// reset: synchronous active low, clears the window, sets actuator registers and
//   configuration to their defaults; no clearing pass, ready right after reset
module serial_command_actuator_decoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [scad_pkg::InDataW-1:0] i_s_tdata,  // [7:0] rx_byte
    input  logic                        i_s_tuser,  // [0] rx_error
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [15:0] motor_duty, [16] forward_pin, [17] backward_pin, [33:18] steer_servo,
    // [49:34] cam_servo_a, [65:50] cam_servo_b, [66] steer_enable, [67] gps_enable,
    // [68] cam_servo_enable, [69] camera_power, [71:70] zero
    output logic [scad_pkg::OutDataW-1:0] o_m_tdata,
    output logic                        o_m_tuser,  // [0] frame_done
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [scad_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [scad_pkg::CfgDataW-1:0] i_cfg_data
);
    import scad_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_err;
    logic             r_out_valid;
    logic             r_done;
    t_cfg             r_cfg;
    logic             w_out_free;
    logic             w_adv;
    logic             w_step;
    t_frame           w_frame;
    t_act             w_act;
    logic [FillW-1:0] w_fill;

    // handshake: the result stage frees when empty or being taken
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_adv       = r_in_valid && w_out_free;
    assign w_step      = w_adv && !r_in_err;
    assign o_s_tready  = !r_in_valid || w_out_free;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_err  <= i_s_tuser;
        end
    end

    // result valid and frame done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
            if (w_adv) begin
                r_done <= w_step && w_frame.match;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.servo_center <= RstServoCenter;
            r_cfg.servo_step   <= RstServoStep;
            r_cfg.motor_gain   <= RstMotorGain;
            r_cfg.stop_duty    <= RstStopDuty;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SERVO_CENTER: r_cfg.servo_center <= i_cfg_data[13:0];
                CFG_SERVO_STEP:   r_cfg.servo_step   <= i_cfg_data[3:0];
                CFG_MOTOR_GAIN:   r_cfg.motor_gain   <= i_cfg_data[7:0];
                CFG_STOP_DUTY:    r_cfg.stop_duty    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    scad_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step),
        .i_byte  (r_in_byte),
        .o_frame (w_frame),
        .o_fill  (w_fill)
    );

    scad_actuator u_actuator (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step),
        .i_frame (w_frame),
        .i_cfg   (r_cfg),
        .o_act   (w_act)
    );

    // result packing
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_done;
    assign o_m_tdata  = {2'b00, w_act.flags, w_act.cam_b, w_act.cam_a, w_act.steer,
                         w_act.dir, w_act.duty};

    // a completed frame leaves an empty window behind
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (w_fill == '0))
        else $error("frame done with a non-empty window");

    // actuator state only moves when an item passes to the result stage
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(o_m_tdata))
        else $error("actuator state changed without a transfer");

    // every item passed on shows up as a result in the next cycle
    a_adv_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_tvalid)
        else $error("item lost between input and result stage");

    // an errored byte never completes a frame
    a_err_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_err) |=> !o_m_tuser)
        else $error("errored byte flagged a frame");

endmodule
